// ===== hdl/word_copy_dma_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the word copy DMA engine
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef WORD_COPY_DMA_ENGINE_ASSERT_SVH
`define WORD_COPY_DMA_ENGINE_ASSERT_SVH

// Same-cycle implication, masked during reset
`define WCDE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset
`define WCDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/wcde_pkg.sv =====
// ----------------------------------------------------------------------------
// wcde_pkg
// Types and constants shared by the word copy DMA engine.
// ----------------------------------------------------------------------------
package wcde_pkg;

    localparam int unsigned WordW = 32;

    // Register offsets from the configured base
    localparam logic [WordW-1:0] REG_SOURCE = 32'h0;
    localparam logic [WordW-1:0] REG_DEST   = 32'h4;
    localparam logic [WordW-1:0] REG_SIZE   = 32'h8;
    localparam logic [WordW-1:0] REG_START  = 32'hc;

    localparam logic [WordW-1:0] WORD_BYTES = 32'd4;

    typedef struct packed {
        logic             clear_line;
        logic [WordW-1:0] bus_address;
        logic [WordW-1:0] bus_data;
        logic [WordW-1:0] memory_read_data;
    } t_req;

    typedef struct packed {
        logic [WordW-1:0] memory_address;
        logic [WordW-1:0] memory_write_data;
        logic             write_not_read;
        logic             done_interrupt;
    } t_rsp;

    // One-hot register write strobes from the slave decoder
    typedef struct packed {
        logic source;
        logic dest;
        logic size;
        logic start;
    } t_reg_sel;

endpackage

// ===== hdl/wcde_req_if.sv =====
// ----------------------------------------------------------------------------
// wcde_req_if
// Valid/ready channel carrying one bus tick request.
// ----------------------------------------------------------------------------
interface wcde_req_if;
    import wcde_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/wcde_rsp_if.sv =====
// ----------------------------------------------------------------------------
// wcde_rsp_if
// Valid/ready channel carrying the master bus view after one tick.
// ----------------------------------------------------------------------------
interface wcde_rsp_if;
    import wcde_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/wcde_decode.sv =====
// ----------------------------------------------------------------------------
// wcde_decode
// Slave address decoder: matches the bus address against the four registers.
// ----------------------------------------------------------------------------
module wcde_decode
    import wcde_pkg::*;
(
    input  logic [WordW-1:0] i_bus_address,
    input  logic [WordW-1:0] i_register_base,
    output t_reg_sel         o_sel
);

    logic [WordW-1:0] rel;

    // offset wraps modulo 2^32
    assign rel = i_bus_address - i_register_base;

    always_comb begin
        o_sel = '0;
        unique case (rel)
            REG_SOURCE: o_sel.source = 1'b1;
            REG_DEST:   o_sel.dest   = 1'b1;
            REG_SIZE:   o_sel.size   = 1'b1;
            REG_START:  o_sel.start  = 1'b1;
            default:    o_sel        = '0;
        endcase
    end

endmodule

// ===== hdl/wcde_core.sv =====
// ----------------------------------------------------------------------------
// wcde_core
// Control registers and the four-phase word copy sequencer.
// ----------------------------------------------------------------------------
module wcde_core
    import wcde_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_advance,
    input  t_req     i_req,
    input  t_reg_sel i_sel,
    output t_rsp     o_rsp
);

    localparam logic [1:0] PH_ISSUE = 2'd0;
    localparam logic [1:0] PH_WAIT  = 2'd1;
    localparam logic [1:0] PH_LATCH = 2'd2;
    localparam logic [1:0] PH_WRITE = 2'd3;

    logic [WordW-1:0] r_source,    n_source;
    logic [WordW-1:0] r_dest,      n_dest;
    logic [WordW-1:0] r_bytes,     n_bytes;
    logic [WordW-1:0] r_start,     n_start;
    logic [1:0]       r_phase,     n_phase;
    logic [WordW-1:0] r_offset,    n_offset;
    logic [WordW-1:0] r_held,      n_held;
    logic             r_irq,       n_irq;
    logic [WordW-1:0] r_addr_out,  n_addr_out;
    logic [WordW-1:0] r_wdata_out, n_wdata_out;
    logic             r_rw_out,    n_rw_out;

    logic             running;
    logic             tail;
    logic [WordW-1:0] step;

    assign running = (r_start == 32'd1);
    assign tail    = (r_bytes[WordW-1:2] == '0);
    // whole word uses the running offset, a short tail uses the byte count
    assign step    = tail ? r_bytes : r_offset;

    always_comb begin
        n_source    = r_source;
        n_dest      = r_dest;
        n_bytes     = r_bytes;
        n_start     = r_start;
        n_phase     = r_phase;
        n_offset    = r_offset;
        n_held      = r_held;
        n_irq       = r_irq;
        n_addr_out  = r_addr_out;
        n_wdata_out = r_wdata_out;
        n_rw_out    = r_rw_out;

        priority if (running) begin
            if (r_bytes != '0) begin
                unique case (r_phase)
                    PH_ISSUE: begin
                        n_addr_out  = r_source + step;
                        n_wdata_out = '0;
                        n_rw_out    = 1'b0;
                        n_phase     = PH_WAIT;
                    end
                    PH_WAIT: begin
                        n_phase = PH_LATCH;
                    end
                    PH_LATCH: begin
                        n_held  = i_req.memory_read_data;
                        n_phase = PH_WRITE;
                    end
                    PH_WRITE: begin
                        n_addr_out  = r_dest + step;
                        n_wdata_out = r_held;
                        n_rw_out    = 1'b1;
                        n_phase     = PH_ISSUE;
                        if (tail) begin
                            n_bytes = '0;
                        end else begin
                            n_offset = r_offset + WORD_BYTES;
                            n_bytes  = r_bytes - WORD_BYTES;
                        end
                    end
                    default: n_phase = PH_ISSUE;
                endcase
            end else begin
                n_irq   = 1'b1;
                n_start = '0;
            end
        end else if (i_req.clear_line && r_irq) begin
            // acknowledge: phase and master outputs are kept
            n_source = '0;
            n_dest   = '0;
            n_bytes  = '0;
            n_start  = '0;
            n_offset = '0;
            n_held   = '0;
            n_irq    = 1'b0;
        end else if (!i_req.clear_line) begin
            if (i_sel.source) n_source = i_req.bus_data;
            if (i_sel.dest)   n_dest   = i_req.bus_data;
            if (i_sel.size)   n_bytes  = i_req.bus_data;
            if (i_sel.start)  n_start  = i_req.bus_data;
        end else begin
            // hold everything: clear with no interrupt pending
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source    <= '0;
            r_dest      <= '0;
            r_bytes     <= '0;
            r_start     <= '0;
            r_phase     <= PH_ISSUE;
            r_offset    <= '0;
            r_held      <= '0;
            r_irq       <= 1'b0;
            r_addr_out  <= '0;
            r_wdata_out <= '0;
            r_rw_out    <= 1'b0;
        end else if (i_advance) begin
            r_source    <= n_source;
            r_dest      <= n_dest;
            r_bytes     <= n_bytes;
            r_start     <= n_start;
            r_phase     <= n_phase;
            r_offset    <= n_offset;
            r_held      <= n_held;
            r_irq       <= n_irq;
            r_addr_out  <= n_addr_out;
            r_wdata_out <= n_wdata_out;
            r_rw_out    <= n_rw_out;
        end
    end

    assign o_rsp.memory_address    = r_addr_out;
    assign o_rsp.memory_write_data = r_wdata_out;
    assign o_rsp.write_not_read    = r_rw_out;
    assign o_rsp.done_interrupt    = r_irq;

endmodule

// ===== hdl/word_copy_dma_engine.sv =====
// ----------------------------------------------------------------------------
// word_copy_dma_engine
// Word copy DMA controller stepped one bus tick per request.
// ----------------------------------------------------------------------------
// Each request on i_req is one clock tick of the system bus: the slave address
// and data, the clear line and the memory read data. The engine takes one
// request every cycle while its responses are taken and returns exactly one
// response per request, in the cycle after it is accepted, giving the master
// address, write data, access kind and the done interrupt as they stand after
// that tick. The response register is the engine's own state (master outputs
// and interrupt); a stalled response holds i_req.ready low until it is taken.
// While no transfer runs, slave writes with clear_line low at base + 0x0, 0x4,
// 0x8 and 0xc load source, destination, byte count and start; the base comes
// from the configuration register written through i_cfg_wr_en / i_cfg_wr_data.
// Writing start to one with a non-zero count runs the copy: every word goes
// through four phases, one request each (issue read, wait, latch data, write),
// and a tail under four bytes is addressed at the source or destination start
// plus the remaining count. When the count reaches zero the interrupt rises and
// holds until a request with clear_line set acknowledges it.
// ----------------------------------------------------------------------------
module word_copy_dma_engine
    import wcde_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    wcde_req_if.sink         i_req,
    wcde_rsp_if.source       o_rsp,
    input  logic             i_cfg_wr_en,
    input  logic [WordW-1:0] i_cfg_wr_data
);

    logic [WordW-1:0] r_register_base;
    logic             r_rsp_valid, n_rsp_valid;
    logic             advance;
    t_reg_sel         sel;
    t_rsp             core_rsp;

    // Take a new request whenever the response slot is empty or being drained
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign advance     = i_req.valid && i_req.ready;

    // Hold the response until taken, refill it on every accepted request
    assign n_rsp_valid = advance || (r_rsp_valid && !o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid     <= 1'b0;
            r_register_base <= '0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_wr_en) begin
                r_register_base <= i_cfg_wr_data;
            end
        end
    end

    // Slave address decode against the configured base
    wcde_decode u_decode (
        .i_bus_address   (i_req.payload.bus_address),
        .i_register_base (r_register_base),
        .o_sel           (sel)
    );

    // Control registers and copy sequencer; advance only on accepted requests
    wcde_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_req     (i_req.payload),
        .i_sel     (sel),
        .o_rsp     (core_rsp)
    );

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = core_rsp;

endmodule

// ===== hdl/wcde_checker.sv =====
// ----------------------------------------------------------------------------
// wcde_checker
// Port-level checks on the word copy DMA engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "word_copy_dma_engine_assert.svh"

module wcde_checker
    import wcde_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp
);

    `WCDE_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp), "stalled response changed")
    `WCDE_ASSERT_NEXT(a_req_to_rsp, i_clk, i_rst_n, i_req_valid && i_req_ready, i_rsp_valid, "accepted request gave no response")
    `WCDE_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_rsp_valid, i_req_ready, "request refused with empty response slot")
    `WCDE_ASSERT_NOW(a_read_zero_data, i_clk, i_rst_n, i_rsp_valid && !i_rsp.write_not_read, i_rsp.memory_write_data == '0, "read carries write data")

endmodule

bind word_copy_dma_engine wcde_checker u_wcde_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the word copy DMA engine. Bus requests are queued
// by the stimulus process, fed through the request channel by a clocked
// driver and predicted at acceptance by a cycle model of the engine held in
// this file; a clocked monitor takes each response and compares it field by
// field with the oldest predicted master bus view.
// ----------------------------------------------------------------------------
module tb;
    import wcde_pkg::*;

    // Copy sequencer phases of one word move
    typedef enum logic [1:0] {
        PH_ISSUE,
        PH_WAIT,
        PH_LATCH,
        PH_WRITE
    } t_copy_phase;

    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned QUIET_LIMIT    = 4000;
    localparam int unsigned TAIL_CYCLES    = 4;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [WordW-1:0] i_cfg_wr_data;

    wcde_req_if req_if ();
    wcde_rsp_if rsp_if ();

    word_copy_dma_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_if),
        .o_rsp         (rsp_if),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Requests waiting for the driver, and master views still owed by the engine
    t_req pending_reqs[$];
    t_rsp expected_views[$];

    // Shadow of the engine: configured base, control registers and master outputs
    logic [WordW-1:0] cfg_base;
    logic [WordW-1:0] sh_source;
    logic [WordW-1:0] sh_dest;
    logic [WordW-1:0] sh_left;
    logic [WordW-1:0] sh_start;
    logic [WordW-1:0] sh_offset;
    logic [WordW-1:0] sh_held;
    logic [WordW-1:0] sh_addr;
    logic [WordW-1:0] sh_wdata;
    logic             sh_rw;
    logic             sh_irq;
    t_copy_phase      sh_phase;

    // Idling and pressure controls, set by the stimulus process
    int unsigned src_idle_pct;
    int unsigned rx_idle_pct;
    logic        rx_hold_go;
    int unsigned rx_hold_left;

    int unsigned queued_cnt;
    int unsigned req_cnt;
    int unsigned view_cnt;
    int unsigned copies_done;
    int unsigned base_writes;
    int unsigned fail_cnt;
    int unsigned quiet_cycles;

    t_rsp got_view;
    t_rsp want_view;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Cycle model: advance the shadow state by one bus request and return the
    // master view the engine must show for it.
    // ------------------------------------------------------------------------
    function automatic t_rsp step_copy_engine(input t_req r);
        t_rsp             view;
        logic [WordW-1:0] rel;
        rel = r.bus_address - cfg_base;
        if (sh_start == 32'd1) begin
            // Running: slave writes and clear are ignored
            if (sh_left != '0) begin
                case (sh_phase)
                    PH_ISSUE: begin
                        // A tail under one word reads at source plus the remaining count
                        sh_addr  = sh_source + ((sh_left >= WORD_BYTES) ? sh_offset : sh_left);
                        sh_wdata = '0;
                        sh_rw    = 1'b0;
                        sh_phase = PH_WAIT;
                    end
                    PH_WAIT: begin
                        sh_phase = PH_LATCH;
                    end
                    PH_LATCH: begin
                        sh_held  = r.memory_read_data;
                        sh_phase = PH_WRITE;
                    end
                    default: begin
                        if (sh_left >= WORD_BYTES) begin
                            sh_addr   = sh_dest + sh_offset;
                            sh_offset = sh_offset + WORD_BYTES;
                            sh_left   = sh_left - WORD_BYTES;
                        end else begin
                            // Tail: the offset stays put and the count drops to zero
                            sh_addr = sh_dest + sh_left;
                            sh_left = '0;
                        end
                        sh_wdata = sh_held;
                        sh_rw    = 1'b1;
                        sh_phase = PH_ISSUE;
                    end
                endcase
            end else begin
                sh_irq   = 1'b1;
                sh_start = '0;
                copies_done++;
            end
        end else if (r.clear_line && sh_irq) begin
            // Acknowledge: drop the control registers but keep phase and master outputs
            sh_source = '0;
            sh_dest   = '0;
            sh_left   = '0;
            sh_start  = '0;
            sh_offset = '0;
            sh_held   = '0;
            sh_irq    = 1'b0;
        end else if (!r.clear_line) begin
            case (rel)
                REG_SOURCE: sh_source = r.bus_data;
                REG_DEST:   sh_dest   = r.bus_data;
                REG_SIZE:   sh_left   = r.bus_data;
                REG_START:  sh_start  = r.bus_data;
                default:    ;
            endcase
        end
        view.memory_address    = sh_addr;
        view.memory_write_data = sh_wdata;
        view.write_not_read    = sh_rw;
        view.done_interrupt    = sh_irq;
        return view;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    function automatic void push_req(input logic clr, input logic [WordW-1:0] addr,
                                     input logic [WordW-1:0] data,
                                     input logic [WordW-1:0] mem);
        t_req r;
        r.clear_line       = clr;
        r.bus_address      = addr;
        r.bus_data         = data;
        r.memory_read_data = mem;
        pending_reqs.push_back(r);
        queued_cnt++;
    endfunction

    // Source and destination: now and then close to the top so that sums wrap
    function automatic logic [WordW-1:0] pick_addr();
        logic [WordW-1:0] a;
        if ($urandom_range(3) == 0) a = 32'hFFFF_FFFF - $urandom_range(15);
        else                        a = $urandom;
        return a;
    endfunction

    // Mostly short copies, a few long ones
    function automatic logic [WordW-1:0] pick_size();
        logic [WordW-1:0] s;
        case ($urandom_range(19))
            0:       s = $urandom_range(65, 128);
            1, 2, 3: s = $urandom_range(25, 64);
            default: s = $urandom_range(0, 24);
        endcase
        return s;
    endfunction

    // One request while a copy runs. Register hits here must be ignored, and
    // they never arm a copy or load a long count should the engine be idle.
    function automatic void push_run_req();
        logic [WordW-1:0] addr;
        logic [WordW-1:0] data;
        data = $urandom;
        case ($urandom_range(5))
            0: addr = cfg_base + REG_SOURCE;
            1: addr = cfg_base + REG_DEST;
            2: begin
                addr = cfg_base + REG_SIZE;
                data = $urandom_range(64);
            end
            3: begin
                addr = cfg_base + REG_START;
                if (data == 32'd1) data = 32'd3;
            end
            default: addr = $urandom;
        endcase
        push_req(1'($urandom_range(1)), addr, data, $urandom);
    endfunction

    // Stray request: register hits, near misses and random slave traffic
    function automatic void push_stray();
        logic [WordW-1:0] addr;
        logic [WordW-1:0] data;
        int unsigned      near;
        data = $urandom;
        case ($urandom_range(9))
            0: addr = cfg_base + REG_SOURCE;
            1: addr = cfg_base + REG_DEST;
            2: begin
                addr = cfg_base + REG_SIZE;
                data = $urandom_range(64);
            end
            3: begin
                addr = cfg_base + REG_START;
                if ($urandom_range(1)) data = '0;
                else if (data == 32'd1) data = 32'd2;
            end
            4, 5: begin
                // Just off a register slot
                near = $urandom_range(1, 20);
                if (near % 4 == 0 && near <= 12) near++;
                addr = cfg_base + near;
            end
            6: addr = cfg_base - WORD_BYTES;
            default: addr = $urandom;
        endcase
        push_req(1'($urandom_range(1)), addr, data, $urandom);
    endfunction

    // Program a copy and run it. Most run to the interrupt; some are cut short
    // and some leave the start word at a value other than one.
    function automatic void push_copy();
        logic [WordW-1:0] size;
        logic [WordW-1:0] start_val;
        logic [WordW-1:0] slot;
        logic [WordW-1:0] slots [3];
        int unsigned      rot;
        int unsigned      span;
        int unsigned      kind;
        kind     = $urandom_range(99);
        size     = pick_size();
        slots[0] = REG_SOURCE;
        slots[1] = REG_DEST;
        slots[2] = REG_SIZE;
        rot      = $urandom_range(2);
        for (int i = 0; i < 3; i++) begin
            slot = slots[(i + rot) % 3];
            push_req(1'b0, cfg_base + slot, (slot == REG_SIZE) ? size : pick_addr(), $urandom);
        end
        // Four requests per word or tail, then one more to raise the interrupt
        span      = 4 * ((size + 3) / 4) + 1;
        start_val = 32'd1;
        if (kind < 12) begin
            start_val = $urandom;
            if (start_val == 32'd1) start_val = '0;
            span = $urandom_range(1, 4);
        end else if (kind < 27) begin
            span = $urandom_range(span - 1);
        end
        push_req(1'b0, cfg_base + REG_START, start_val, $urandom);
        repeat (span) push_run_req();
        if ($urandom_range(9) < 7) push_req(1'b1, $urandom, $urandom, $urandom);
    endfunction

    task automatic queue_random(input int unsigned n);
        int unsigned target;
        target = queued_cnt + n;
        while (queued_cnt < target) begin
            if ($urandom_range(99) < 85) push_copy();
            else repeat ($urandom_range(1, 3)) push_stray();
        end
    endtask

    // Extremes of the fields, register decode and the special cases
    task automatic queue_directed();
        // Clear with no interrupt pending does nothing
        push_req(1'b1, cfg_base + REG_SOURCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Full-scale count with a start word other than one stays idle
        push_req(1'b0, cfg_base + REG_SIZE, 32'hFFFF_FFFF, 32'h0);
        push_req(1'b0, cfg_base + REG_START, 32'hFFFF_FFFF, 32'h0);
        push_req(1'b0, cfg_base + 32'd2, 32'd1, 32'h0);
        push_req(1'b0, cfg_base + 32'd16, 32'd1, 32'h0);
        // One word plus a two-byte tail, the destination tail address wrapping past the top
        push_req(1'b0, cfg_base + REG_SOURCE, 32'hFFFF_FFFC, 32'h0);
        push_req(1'b0, cfg_base + REG_DEST, 32'hFFFF_FFFE, 32'h0);
        push_req(1'b0, cfg_base + REG_SIZE, 32'd6, 32'h0);
        push_req(1'b0, cfg_base + REG_START, 32'd1, 32'h0);
        push_req(1'b1, cfg_base + REG_SIZE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(1'b0, cfg_base + REG_START, 32'd0, 32'h0);
        push_req(1'b0, cfg_base + REG_SIZE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(1'b1, cfg_base + REG_SOURCE, 32'h0, 32'hFFFF_FFFF);
        push_req(1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0);
        push_req(1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0);
        push_req(1'b0, cfg_base + REG_DEST, 32'h0, 32'hFFFF_FFFF);
        push_req(1'b0, cfg_base + REG_SIZE, 32'hFFFF_FFFF, 32'h0);
        // This one raises the interrupt
        push_req(1'b1, cfg_base + REG_START, 32'd1, 32'h0);
        // Acknowledge, then start with a zero count: interrupt on the next request
        push_req(1'b1, 32'h0, 32'h0, 32'h0);
        push_req(1'b0, cfg_base + REG_START, 32'd1, 32'h0);
        push_req(1'b0, cfg_base + REG_SOURCE, 32'h1234_5678, 32'h0);
        push_req(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Hold until every queued request has gone in and every view has come back
    task automatic drain_all();
        while (pending_reqs.size() != 0 || req_if.valid || expected_views.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the base only with the engine quiet
    task automatic program_base(input logic [WordW-1:0] value);
        drain_all();
        repeat (2) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_base = value;
        base_writes++;
        i_cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer pending requests, predict each one as it is accepted
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid   <= 1'b0;
            req_if.payload <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_views.push_back(step_copy_engine(req_if.payload));
                req_cnt++;
            end
            // Advance only when the slot is free or its request has just gone
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    req_if.payload <= pending_reqs.pop_front();
                    req_if.valid   <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here on request from the stimulus
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold_left <= 0;
        end else if (rx_hold_go) begin
            rx_hold_left <= RX_HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    function automatic void check_field(input string name, input logic [WordW-1:0] want,
                                        input logic [WordW-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
            fail_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: take responses and compare with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got_view = rsp_if.payload;
                view_cnt++;
                if (expected_views.size() == 0) begin
                    $error("response with no request outstanding: addr 0x%08h",
                           got_view.memory_address);
                    fail_cnt++;
                end else begin
                    want_view = expected_views.pop_front();
                    check_field("memory_address", want_view.memory_address,
                                got_view.memory_address);
                    check_field("memory_write_data", want_view.memory_write_data,
                                got_view.memory_write_data);
                    check_field("write_not_read", {31'b0, want_view.write_not_read},
                                {31'b0, got_view.write_not_read});
                    check_field("done_interrupt", {31'b0, want_view.done_interrupt},
                                {31'b0, got_view.done_interrupt});
                end
            end
            rsp_if.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: count cycles with work outstanding and nothing moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (pending_reqs.size() == 0 && !req_if.valid && expected_views.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: nothing accepted for %0d cycles, %0d views outstanding",
                     quiet_cycles, expected_views.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        rx_hold_go     = 1'b0;
        src_idle_pct   = 0;
        rx_idle_pct    = 0;
        cfg_base       = '0;
        sh_source      = '0;
        sh_dest        = '0;
        sh_left        = '0;
        sh_start       = '0;
        sh_offset      = '0;
        sh_held        = '0;
        sh_addr        = '0;
        sh_wdata       = '0;
        sh_rw          = 1'b0;
        sh_irq         = 1'b0;
        sh_phase       = PH_ISSUE;
        queued_cnt     = 0;
        req_cnt        = 0;
        view_cnt       = 0;
        copies_done    = 0;
        base_writes    = 0;
        fail_cnt       = 0;
        quiet_cycles   = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender mostly busy, receiver mostly stalling; base at zero
        src_idle_pct = 15;
        rx_idle_pct  = 76;
        program_base(32'h0);
        queue_directed();
        queue_random(420);
        // Hold the receiver off while requests keep coming, so the input backs up
        while (pending_reqs.size() > 300) @(posedge i_clk);
        rx_hold_go <= 1'b1;
        @(posedge i_clk);
        rx_hold_go <= 1'b0;

        // Roles swapped; base at the top so register slots wrap past zero
        src_idle_pct = 76;
        rx_idle_pct  = 15;
        program_base(32'hFFFF_FFFF);
        queue_random(200);
        // Pause the sender until every view has come back
        drain_all();
        queue_random(240);

        // No idling on either side, two more bases
        src_idle_pct = 0;
        rx_idle_pct  = 0;
        program_base($urandom);
        queue_random(430);
        program_base(32'hFFFF_FFF8);
        queue_random(430);

        drain_all();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_views.size() != 0) begin
            $error("%0d predicted views never arrived", expected_views.size());
            fail_cnt++;
        end

        $display("Checked %0d master views from %0d bus requests over %0d base settings",
                 view_cnt, req_cnt, base_writes);
        $display("%0d copies ran to the interrupt, with wrapped addresses, tails and stalls",
                 copies_done);
        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
